>>> rtl/dsrs_pkg.sv
// ----------------------------------------------------------------------------
// dsrs_pkg
// Shared request codes, constants and the divider pipeline item type for the
// DPI scaling unit.
// ----------------------------------------------------------------------------
package dsrs_pkg;

    // Request kinds carried in the slave tuser field.
    typedef enum logic [1:0] {
        REQ_CEIL_UP   = 2'd0,
        REQ_NEAR_UP   = 2'd1,
        REQ_NEAR_DOWN = 2'd2,
        REQ_RESERVED  = 2'd3
    } req_type_t;

    localparam logic [63:0] SIGNED_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SIGNED_MIN = 64'h8000_0000_0000_0000;

    // Long division: quotient bits resolved per stage and number of stages.
    localparam int DIV_BITS   = 8;
    localparam int DIV_STAGES = 8;

    // One item traveling through the divider stages.
    typedef struct packed {
        logic        zero;
        logic        neg;
        logic        ovf;
        logic        ceil_mode;
        logic [15:0] div;
        logic [15:0] rem;
        logic [63:0] quo;
    } div_item_t;

endpackage

>>> rtl/dpi_scale_round_saturate.sv
// ----------------------------------------------------------------------------
// dpi_scale_round_saturate
// Scales a coordinate by dpi / reference_dpi or its inverse, with rounding and
// signed 64-bit saturation.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle unless every stage is full and the output
// stalls; the 64x16 product is formed as two 32x16 partial products and the
// quotient by eight divider stages of eight bits each.
// Stages advance independently, so bubbles close up while the output stalls.
// Reset clears all valid bits and loads reference_dpi with 96.
module dpi_scale_round_saturate
    import dsrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write: reference_dpi.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // Requests.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // [63:0] value, [79:64] dpi
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] result
    output logic [0:0]  m_tuser    // [0] saturated
);

    localparam int NSTG = DIV_STAGES + 5;

    logic [15:0] ref_reg;
    logic [NSTG-1:0] stg_v;
    logic [2:0] v_head_reg;
    logic [1:0] v_tail_reg;
    logic [NSTG-1:0] ld;

    // Configuration register is always writable.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= 16'd96;
        end
        else if (cfg_valid)
        begin
            ref_reg <= cfg_data;
        end
    end

    // A stage loads when it is empty or the stage after it loads.
    always_comb
    begin
        ld[NSTG-1] = !stg_v[NSTG-1] || m_tready;
        for (int i = NSTG-2; i >= 0; i--)
        begin
            ld[i] = !stg_v[i] || ld[i+1];
        end
    end

    assign s_tready = ld[0];

    // Valid bits for the stages outside the divider.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_head_reg <= '0;
            v_tail_reg <= '0;
        end
        else
        begin
            if (ld[0])      v_head_reg[0] <= s_tvalid;
            if (ld[1])      v_head_reg[1] <= v_head_reg[0];
            if (ld[2])      v_head_reg[2] <= v_head_reg[1];
            if (ld[NSTG-2]) v_tail_reg[0] <= stg_v[NSTG-3];
            if (ld[NSTG-1]) v_tail_reg[1] <= v_tail_reg[0];
        end
    end

    assign stg_v[2:0]         = v_head_reg;
    assign stg_v[NSTG-1:NSTG-2] = v_tail_reg;

    // Stage 0: decode the request into magnitude, multiplier and divisor.
    logic [63:0] mag_next, mag_reg;
    logic [15:0] mul_next, mul_reg, div_next, div0_reg;
    logic        neg_next, neg0_reg, zero_next, zero0_reg, ceil_next, ceil0_reg;

    always_comb
    begin
        logic [63:0] val;
        val       = s_tdata[63:0];
        mag_next  = '0;
        mul_next  = '0;
        div_next  = '0;
        neg_next  = 1'b0;
        ceil_next = 1'b0;
        zero_next = 1'b1;
        case (s_tuser)
            REQ_CEIL_UP:
            begin
                mag_next  = {32'd0, val[31:0]};
                mul_next  = s_tdata[79:64];
                div_next  = ref_reg;
                ceil_next = 1'b1;
                zero_next = 1'b0;
            end
            REQ_NEAR_UP:
            begin
                neg_next  = val[63];
                mag_next  = val[63] ? (64'd0 - val) : val;
                mul_next  = s_tdata[79:64];
                div_next  = ref_reg;
                zero_next = 1'b0;
            end
            REQ_NEAR_DOWN:
            begin
                neg_next  = val[63];
                mag_next  = val[63] ? (64'd0 - val) : val;
                mul_next  = ref_reg;
                div_next  = s_tdata[79:64];
                zero_next = 1'b0;
            end
            default:
            begin
                zero_next = 1'b1;
            end
        endcase
        if (mul_next == 16'd0 || div_next == 16'd0)
        begin
            zero_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            mag_reg   <= mag_next;
            mul_reg   <= mul_next;
            div0_reg  <= div_next;
            neg0_reg  <= neg_next;
            zero0_reg <= zero_next;
            ceil0_reg <= ceil_next;
        end
    end

    // Stage 1: two 32x16 partial products.
    logic [47:0] plo_reg, phi_reg;
    logic [15:0] div1_reg;
    logic        neg1_reg, zero1_reg, ceil1_reg;

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            plo_reg   <= mag_reg[31:0] * mul_reg;
            phi_reg   <= mag_reg[63:32] * mul_reg;
            div1_reg  <= div0_reg;
            neg1_reg  <= neg0_reg;
            zero1_reg <= zero0_reg;
            ceil1_reg <= ceil0_reg;
        end
    end

    // Stage 2: sum the partial products and flag a product beyond 64 bits.
    logic [79:0] prod;
    div_item_t   item2_next, item2_reg;

    always_comb
    begin
        prod                 = {32'd0, plo_reg} + {phi_reg, 32'd0};
        item2_next.zero      = zero1_reg;
        item2_next.neg       = neg1_reg;
        item2_next.ovf       = |prod[79:64];
        item2_next.ceil_mode = ceil1_reg;
        item2_next.div       = div1_reg;
        item2_next.rem       = '0;
        item2_next.quo       = prod[63:0];
    end

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            item2_reg <= item2_next;
        end
    end

    // Stages 3 to 10: pipelined long division.
    div_item_t div_item [DIV_STAGES+1];
    logic      div_v    [DIV_STAGES+1];

    assign div_item[0] = item2_reg;
    assign div_v[0]    = stg_v[2];

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        dsrs_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (ld[g+3]),
            .in_valid  (div_v[g]),
            .in_item   (div_item[g]),
            .out_valid (div_v[g+1]),
            .out_item  (div_item[g+1])
        );
        assign stg_v[g+3] = div_v[g+1];
    end

    // Stage 11: rounding increment.
    div_item_t   dq;
    logic        round_up;
    logic [64:0] scaled_reg;
    logic        neg_s_reg, zero_s_reg, ovf_s_reg;

    always_comb
    begin
        dq = div_item[DIV_STAGES];
        if (dq.ceil_mode)
        begin
            round_up = (dq.rem != 16'd0);
        end
        else
        begin
            round_up = ({dq.rem, 1'b0} >= {1'b0, dq.div});
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[NSTG-2])
        begin
            scaled_reg <= {1'b0, dq.quo} + {64'd0, round_up};
            neg_s_reg  <= dq.neg;
            zero_s_reg <= dq.zero;
            ovf_s_reg  <= dq.ovf;
        end
    end

    // Stage 12: sign and saturation into the output register.
    logic [63:0] res_next, res_reg;
    logic        sat_next, sat_reg;

    always_comb
    begin
        res_next = '0;
        sat_next = 1'b0;
        if (zero_s_reg)
        begin
            res_next = '0;
        end
        else if (ovf_s_reg)
        begin
            res_next = neg_s_reg ? SIGNED_MIN : SIGNED_MAX;
            sat_next = 1'b1;
        end
        else if (neg_s_reg)
        begin
            if (scaled_reg > {1'b0, SIGNED_MIN})
            begin
                res_next = SIGNED_MIN;
                sat_next = 1'b1;
            end
            else
            begin
                res_next = 64'd0 - scaled_reg[63:0];
            end
        end
        else
        begin
            if (scaled_reg > {1'b0, SIGNED_MAX})
            begin
                res_next = SIGNED_MAX;
                sat_next = 1'b1;
            end
            else
            begin
                res_next = scaled_reg[63:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[NSTG-1])
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign m_tvalid = stg_v[NSTG-1];
    assign m_tdata  = res_reg;
    assign m_tuser  = sat_reg;

endmodule

>>> rtl/dsrs_div_stage.sv
// ----------------------------------------------------------------------------
// dsrs_div_stage
// One registered stage of the restoring divider, resolving DIV_BITS quotient
// bits of a 64-bit dividend by a 16-bit divisor.
// ----------------------------------------------------------------------------
module dsrs_div_stage
    import dsrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  logic      in_valid,
    input  div_item_t in_item,
    output logic      out_valid,
    output div_item_t out_item
);

    logic      valid_reg;
    div_item_t item_reg;
    div_item_t item_next;

    // Shift the next dividend bits into the partial remainder and subtract.
    always_comb
    begin
        logic [16:0] trial;
        item_next = in_item;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial = {item_next.rem, item_next.quo[63]};
            if (trial >= {1'b0, item_next.div})
            begin
                trial = trial - {1'b0, item_next.div};
                item_next.quo = {item_next.quo[62:0], 1'b1};
            end
            else
            begin
                item_next.quo = {item_next.quo[62:0], 1'b0};
            end
            item_next.rem = trial[15:0];
        end
    end

    // Valid bit follows the stage load.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> rtl/dsrs_checker.sv
// ----------------------------------------------------------------------------
// dsrs_checker
// Port-level checks for the DPI scaling unit, bound to the top level.
// ----------------------------------------------------------------------------
module dsrs_checker
    import dsrs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // A stalled result transaction holds its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A saturated result is always one of the two limits.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata == SIGNED_MAX) || (m_tdata == SIGNED_MIN))
        else $error("saturated result is not a limit");

    // Requests are refused only while the output side holds a stalled result.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("request refused without output stall");

endmodule

bind dpi_scale_round_saturate dsrs_checker u_dsrs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> sim/dpi_scale_round_saturate_tb.sv
// ----------------------------------------------------------------------------
// dpi_scale_round_saturate_tb
// Self-checking bench for the DPI scaling unit. Requests are driven on the
// slave stream with random gaps, results are taken with random back-pressure,
// and each result is compared with a prediction of rounding and saturation
// under several reference DPI settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dpi_scale_round_saturate_tb;
    import dsrs_pkg::*;

    typedef struct {
        logic [63:0] result;
        logic        saturated;
    } scaled_t;

    // Holds the expected results in order and checks each output transaction.
    class scale_scoreboard;
        scaled_t     pending[$];
        logic [15:0] ref_dpi;
        int          errors;
        int          checked;

        function new();
            ref_dpi = 16'd96;
            errors  = 0;
            checked = 0;
        endfunction

        // Nearest rounding on the magnitude, then sign and saturation.
        function scaled_t round_nearest(logic [63:0] val, logic [15:0] mul, logic [15:0] dv);
            scaled_t     o;
            logic        neg;
            logic [63:0] mag;
            logic [79:0] prod;
            logic [79:0] q;
            logic [79:0] r;
            logic [79:0] sc;
            o.result    = 64'd0;
            o.saturated = 1'b0;
            if (dv == 0 || mul == 0)
                return o;
            neg  = val[63];
            mag  = neg ? (64'd0 - val) : val;
            prod = {16'd0, mag} * {64'd0, mul};
            if (prod[79:64] != 0)
            begin
                o.result    = neg ? SIGNED_MIN : SIGNED_MAX;
                o.saturated = 1'b1;
                return o;
            end
            q  = prod / dv;
            r  = prod % dv;
            sc = q + ((r >= ({64'd0, dv} + 1) / 2) ? 1 : 0);
            if (neg && sc > {16'd0, SIGNED_MIN})
            begin
                o.result    = SIGNED_MIN;
                o.saturated = 1'b1;
            end
            else if (!neg && sc > {16'd0, SIGNED_MAX})
            begin
                o.result    = SIGNED_MAX;
                o.saturated = 1'b1;
            end
            else
                o.result = neg ? (64'd0 - sc[63:0]) : sc[63:0];
            return o;
        endfunction

        // Notes an accepted request and queues its expected result.
        function void note_request(logic [1:0] kind, logic [63:0] val, logic [15:0] dpi);
            scaled_t     o;
            logic [63:0] prod;
            o.result    = 64'd0;
            o.saturated = 1'b0;
            case (kind)
                REQ_CEIL_UP:
                begin
                    if (dpi != 0 && ref_dpi != 0)
                    begin
                        prod     = {32'd0, val[31:0]} * {48'd0, dpi};
                        o.result = (prod + ref_dpi - 1) / ref_dpi;
                    end
                end
                REQ_NEAR_UP:   o = round_nearest(val, dpi, ref_dpi);
                REQ_NEAR_DOWN: o = round_nearest(val, ref_dpi, dpi);
                default:       ;
            endcase
            pending.push_back(o);
        endfunction

        // Compares one output transaction with the oldest expectation.
        function void check_result(logic [63:0] res, logic sat);
            scaled_t e;
            checked++;
            if (pending.size() == 0)
            begin
                report("unexpected result", 64'd0, res);
                return;
            end
            e = pending.pop_front();
            if (res !== e.result)
                report("result mismatch", e.result, res);
            if (sat !== e.saturated)
                report("saturated mismatch", {63'd0, e.saturated}, {63'd0, sat});
        endfunction

        function void report(string what, logic [63:0] exp_v, logic [63:0] got_v);
            errors++;
            if (errors <= 40)
                $display("MISMATCH %s: expected %h got %h", what, exp_v, got_v);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;

    scale_scoreboard sb;
    bit              sink_steady;
    int              sent;

    dpi_scale_round_saturate i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Result sink with random back-pressure.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser[0]);
            m_tready <= sink_steady ? 1'b1 : ($urandom_range(0, 99) >= 33);
        end
    end

    // Sends one request and waits for its transaction.
    task automatic send_request(logic [1:0] kind, logic [63:0] val, logic [15:0] dpi,
                                bit steady);
        if (!steady)
            while ($urandom_range(0, 99) < 33)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= {dpi, val};
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(kind, val, dpi);
        sent++;
    endtask

    // Stops driving requests and waits until every expected result has arrived.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Writes the reference DPI while the unit is idle.
    task automatic write_ref_dpi(logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.ref_dpi = v;
    endtask

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = v >> $urandom_range(0, 63);
            1: v = -(v >> $urandom_range(0, 63));
            2: v = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0, $urandom};
            3: v = $urandom_range(0, 1) ? SIGNED_MIN : SIGNED_MAX;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] rand_dpi();
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 3));
            1: return 16'hFFFF - 16'($urandom_range(0, 3));
            2: return 16'($urandom_range(72, 300));
            default: return 16'($urandom);
        endcase
    endfunction

    // Timeout.
    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // Main stimulus.
    initial
    begin
        logic [15:0] settings[6];
        sb          = new();
        sent        = 0;
        sink_steady = 1'b0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = 16'd0;
        s_tvalid    = 1'b0;
        s_tdata     = 80'd0;
        s_tuser     = 2'd0;
        m_tready    = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases at the reset reference DPI.
        send_request(REQ_CEIL_UP, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 0);
        send_request(REQ_CEIL_UP, 64'd1, 16'd0, 0);
        send_request(REQ_CEIL_UP, 64'd97, 16'd1, 0);
        send_request(REQ_NEAR_UP, 64'd0, 16'd96, 0);
        send_request(REQ_NEAR_UP, SIGNED_MAX, 16'd2, 0);
        send_request(REQ_NEAR_UP, SIGNED_MIN, 16'd1, 0);
        send_request(REQ_NEAR_UP, SIGNED_MIN, 16'd96, 0);
        send_request(REQ_NEAR_UP, -64'd48, 16'd1, 0);
        send_request(REQ_NEAR_UP, 64'd48, 16'd1, 0);
        send_request(REQ_NEAR_UP, 64'd47, 16'd1, 0);
        send_request(REQ_NEAR_UP, 64'h0001_0000_0000_0000, 16'hFFFF, 0);
        send_request(REQ_NEAR_DOWN, 64'd5, 16'd0, 0);
        send_request(REQ_NEAR_DOWN, SIGNED_MAX, 16'd1, 0);
        send_request(REQ_NEAR_DOWN, SIGNED_MIN, 16'd96, 0);
        send_request(REQ_NEAR_DOWN, -64'd1, 16'd192, 0);
        send_request(REQ_NEAR_DOWN, 64'h0155_5555_5555_5555, 16'd1, 0);
        send_request(REQ_RESERVED, 64'd1234, 16'd96, 0);
        drain();

        // A reference DPI of 1 makes exact minimum results reachable.
        write_ref_dpi(16'd1);
        send_request(REQ_NEAR_UP, SIGNED_MIN, 16'd1, 0);
        send_request(REQ_NEAR_DOWN, 64'hC000_0000_0000_0000, 16'd1, 0);
        send_request(REQ_NEAR_UP, 64'hC000_0000_0000_0000, 16'd2, 0);
        send_request(REQ_NEAR_UP, 64'hBFFF_FFFF_FFFF_FFFF, 16'd2, 0);
        drain();

        // Random phases over several reference DPI settings.
        settings = '{16'd96, 16'd1, 16'hFFFF, 16'd0, 16'd3, 16'd144};
        foreach (settings[p])
        begin
            write_ref_dpi(p == 5 ? 16'($urandom) : settings[p]);
            sink_steady = (p == 2);
            for (int i = 0; i < 200; i++)
                send_request(2'($urandom_range(0, 3)), rand_value(), rand_dpi(), p == 2);
            drain();
        end

        $display("Sent %0d requests in all modes over eight reference DPI settings;",
                 sent);
        $display("checked %0d results with random gaps and back-pressure.", sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> dpi_scale_round_saturate.f
rtl/dsrs_pkg.sv
rtl/dsrs_div_stage.sv
rtl/dpi_scale_round_saturate.sv
rtl/dsrs_checker.sv
sim/dpi_scale_round_saturate_tb.sv
